FILE: rtl/core/mrfe_pkg.sv
// shared types and constants of the modem response field extractor
package mrfe_pkg;

    // lookahead window geometry
    localparam int WIN_DEPTH = 27;
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
    localparam int POS_W     = $clog2(WIN_DEPTH);

    // configuration port
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BOUND  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BOUND = CFG_IDX_W'(1);
    localparam logic [7:0] QUALITY_LOW_RESET  = 8'd10;
    localparam logic [7:0] QUALITY_HIGH_RESET = 8'd40;

    // kind of result transaction
    typedef enum logic [1:0] {
        EV_MAC     = 2'd0,
        EV_IMEI    = 2'd1,
        EV_ICCID   = 2'd2,
        EV_QUALITY = 2'd3
    } event_kind_t;

    // link status carried with a result
    typedef enum logic [1:0] {
        ST_NONE      = 2'd0,
        ST_CONNECTED = 2'd1,
        ST_NORMAL    = 2'd2
    } status_code_t;

    // matched record type
    typedef enum logic [2:0] {
        REC_MAC    = 3'd0,
        REC_SLEMAC = 3'd1,
        REC_IMEI   = 3'd2,
        REC_ICCID  = 3'd3,
        REC_CSQ    = 3'd4
    } rec_kind_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SCAN   = 2'd1,
        S_REC    = 2'd2,
        S_FINISH = 2'd3
    } fsm_state_t;

    // one result item
    typedef struct packed {
        event_kind_t  kind;
        logic [4:0]   byte_index;
        logic [7:0]   byte_value;
        logic [7:0]   quality;
        status_code_t status;
        logic         imei_seen;
        logic         iccid_seen;
        logic         last;
    } result_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic scan;
        logic rec_step;
        logic finish;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic fill_last;
        logic fill_one;
        logic eob;
        logic hit;
        logic emit_want;
        logic rec_end;
        logic pend_free;
        logic pend_valid;
        logic out_can_load;
    } dp_sts_t;

endpackage

FILE: rtl/core/mrfe_ctrl.sv
// controller state machine of the modem response field extractor
module mrfe_ctrl
    import mrfe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    input  logic    s_tlast,
    output logic    s_tready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    fsm_state_t state_reg;
    fsm_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    if (s_tlast || sts.fill_last)
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.hit)
                begin
                    state_next = S_REC;
                end
                else if (sts.eob && !sts.fill_one)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_REC:
            begin
                // walk the record one byte a cycle, hold while no result slot
                if (!sts.emit_want || sts.pend_free)
                begin
                    cmd.rec_step = 1'b1;
                    if (sts.rec_end)
                    begin
                        if (sts.eob && !sts.fill_one)
                        begin
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            state_next = S_FINISH;
                        end
                    end
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                if (!sts.pend_valid || sts.out_can_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/mrfe_dp.sv
// datapath of the modem response field extractor: window, matcher, result slots
module mrfe_dp
    import mrfe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_sts_t              sts,
    input  logic [7:0]           rx_byte,
    input  logic                 rx_eob,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 out_ready,
    output logic                 out_valid,
    output result_t              out_item
);

    localparam logic [39:0] KW_MAC    = "+MAC:";
    localparam logic [55:0] KW_SLEMAC = "+SLEMAC";
    localparam logic [47:0] KW_IMEI   = "IMEI: ";
    localparam logic [55:0] KW_ICCID  = "ICCID: ";
    localparam logic [39:0] KW_CSQ    = "CSQ: ";
    localparam logic [7:0]  DIGIT_0   = "0";

    // bytes skipped per record
    function automatic logic [POS_W-1:0] rec_len_f(rec_kind_t k);
        case (k)
            REC_MAC:    rec_len_f = POS_W'(17);
            REC_SLEMAC: rec_len_f = POS_W'(21);
            REC_IMEI:   rec_len_f = POS_W'(21);
            REC_ICCID:  rec_len_f = POS_W'(27);
            default:    rec_len_f = POS_W'(9);
        endcase
    endfunction

    // first captured position in a record
    function automatic logic [POS_W-1:0] fld_start_f(rec_kind_t k);
        case (k)
            REC_MAC:    fld_start_f = POS_W'(5);
            REC_SLEMAC: fld_start_f = POS_W'(9);
            REC_IMEI:   fld_start_f = POS_W'(6);
            REC_ICCID:  fld_start_f = POS_W'(7);
            default:    fld_start_f = POS_W'(0);
        endcase
    endfunction

    // number of results a record gives
    function automatic logic [POS_W-1:0] fld_len_f(rec_kind_t k);
        case (k)
            REC_MAC:    fld_len_f = POS_W'(12);
            REC_SLEMAC: fld_len_f = POS_W'(12);
            REC_IMEI:   fld_len_f = POS_W'(15);
            REC_ICCID:  fld_len_f = POS_W'(20);
            default:    fld_len_f = POS_W'(1);
        endcase
    endfunction

    logic [7:0]       win_reg [WIN_DEPTH];
    logic [7:0]       win_next [WIN_DEPTH];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic             eob_reg, eob_next;
    rec_kind_t        kind_reg, kind_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [1:0]       seen_reg, seen_next;
    logic [7:0]       low_bound_reg, low_bound_next;
    logic [7:0]       high_bound_reg, high_bound_next;
    logic             pend_valid_reg, pend_valid_next;
    result_t          pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;

    logic             hit;
    rec_kind_t        hit_kind;
    logic             do_shift;
    logic [POS_W-1:0] rec_len_w;
    logic [POS_W-1:0] fld_start_w;
    logic [POS_W-1:0] fld_end_w;
    logic             emit_want;
    logic             gen;
    logic             move;
    logic             out_can_load;
    logic             pend_free;
    logic [7:0]       tens, units, quality;
    result_t          new_item;

    // keyword match at the window head, in priority order
    always_comb
    begin
        hit      = 1'b1;
        hit_kind = REC_CSQ;
        if (fill_reg >= FILL_W'(17) &&
            {win_reg[0], win_reg[1], win_reg[2], win_reg[3], win_reg[4]} == KW_MAC)
        begin
            hit_kind = REC_MAC;
        end
        else if (fill_reg >= FILL_W'(21) &&
            {win_reg[0], win_reg[1], win_reg[2], win_reg[3], win_reg[4], win_reg[5],
             win_reg[6]} == KW_SLEMAC)
        begin
            hit_kind = REC_SLEMAC;
        end
        else if (fill_reg >= FILL_W'(21) &&
            {win_reg[0], win_reg[1], win_reg[2], win_reg[3], win_reg[4],
             win_reg[5]} == KW_IMEI)
        begin
            hit_kind = REC_IMEI;
        end
        else if (fill_reg >= FILL_W'(27) &&
            {win_reg[0], win_reg[1], win_reg[2], win_reg[3], win_reg[4], win_reg[5],
             win_reg[6]} == KW_ICCID)
        begin
            hit_kind = REC_ICCID;
        end
        else if (fill_reg >= FILL_W'(7) &&
            {win_reg[0], win_reg[1], win_reg[2], win_reg[3], win_reg[4]} == KW_CSQ)
        begin
            hit_kind = REC_CSQ;
        end
        else
        begin
            hit = 1'b0;
        end
    end

    // record walk decode
    assign rec_len_w   = rec_len_f(kind_reg);
    assign fld_start_w = fld_start_f(kind_reg);
    assign fld_end_w   = fld_start_w + fld_len_f(kind_reg);
    assign emit_want   = (pos_reg >= fld_start_w) && (pos_reg < fld_end_w);

    // two digit quality value, 8-bit wrap
    assign tens    = win_reg[5] - DIGIT_0;
    assign units   = win_reg[6] - DIGIT_0;
    assign quality = (tens << 3) + (tens << 1) + units;

    // result built from the window head
    always_comb
    begin
        new_item            = '0;
        new_item.byte_index = 5'(pos_reg - fld_start_w);
        new_item.imei_seen  = seen_reg[0];
        new_item.iccid_seen = seen_reg[1];
        new_item.status     = ST_NONE;
        case (kind_reg)
            REC_MAC, REC_SLEMAC:
            begin
                new_item.kind       = EV_MAC;
                new_item.byte_value = win_reg[0];
                if (pos_reg == fld_start_w)
                begin
                    new_item.status = ST_CONNECTED;
                end
            end
            REC_IMEI:
            begin
                new_item.kind       = EV_IMEI;
                new_item.byte_value = win_reg[0];
            end
            REC_ICCID:
            begin
                new_item.kind       = EV_ICCID;
                new_item.byte_value = win_reg[0];
            end
            default:
            begin
                new_item.kind    = EV_QUALITY;
                new_item.quality = quality;
                if (quality > low_bound_reg && quality < high_bound_reg && seen_reg == 2'b11)
                begin
                    new_item.status = ST_NORMAL;
                end
            end
        endcase
    end

    // result slots: pending holds the newest result until its last flag is known
    assign out_can_load = !out_valid_reg || out_ready;
    assign pend_free    = !pend_valid_reg || out_can_load;
    assign gen          = cmd.rec_step && emit_want;
    assign move         = pend_valid_reg && out_can_load && (gen || cmd.finish);
    assign do_shift     = (cmd.scan && !hit) || cmd.rec_step;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
            out_next       = pend_reg;
            out_next.last  = cmd.finish;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (gen)
        begin
            pend_valid_next = 1'b1;
            pend_next       = new_item;
        end
        else if (move)
        begin
            pend_valid_next = 1'b0;
        end
    end

    // window append and shift
    always_comb
    begin
        fill_next = fill_reg;
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (cmd.accept)
        begin
            fill_next = fill_reg + FILL_W'(1);
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                if (fill_reg == FILL_W'(i))
                begin
                    win_next[i] = rx_byte;
                end
            end
        end
        else if (do_shift)
        begin
            fill_next = fill_reg - FILL_W'(1);
            for (int i = 0; i < WIN_DEPTH - 1; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
        end
    end

    // record tracking, sticky flags and configuration
    always_comb
    begin
        eob_next        = eob_reg;
        kind_next       = kind_reg;
        pos_next        = pos_reg;
        seen_next       = seen_reg;
        low_bound_next  = low_bound_reg;
        high_bound_next = high_bound_reg;
        if (cmd.accept)
        begin
            eob_next = rx_eob;
        end
        if (cmd.scan && hit)
        begin
            kind_next = hit_kind;
            pos_next  = '0;
            if (hit_kind == REC_IMEI)
            begin
                seen_next[0] = 1'b1;
            end
            if (hit_kind == REC_ICCID)
            begin
                seen_next[1] = 1'b1;
            end
        end
        else if (cmd.rec_step)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
        if (cfg_valid && cfg_index == CFG_LOW_BOUND)
        begin
            low_bound_next = cfg_data;
        end
        if (cfg_valid && cfg_index == CFG_HIGH_BOUND)
        begin
            high_bound_next = cfg_data;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            eob_reg        <= 1'b0;
            kind_reg       <= REC_MAC;
            pos_reg        <= '0;
            seen_reg       <= '0;
            low_bound_reg  <= QUALITY_LOW_RESET;
            high_bound_reg <= QUALITY_HIGH_RESET;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fill_reg       <= fill_next;
            eob_reg        <= eob_next;
            kind_reg       <= kind_next;
            pos_reg        <= pos_next;
            seen_reg       <= seen_next;
            low_bound_reg  <= low_bound_next;
            high_bound_reg <= high_bound_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            win_reg[i] <= win_next[i];
        end
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    // status to the controller
    assign sts.fill_last    = (fill_reg == FILL_W'(WIN_DEPTH - 1));
    assign sts.fill_one     = (fill_reg == FILL_W'(1));
    assign sts.eob          = eob_reg;
    assign sts.hit          = hit;
    assign sts.emit_want    = emit_want;
    assign sts.rec_end      = (pos_reg == rec_len_w - POS_W'(1)) || (fill_reg == FILL_W'(1));
    assign sts.pend_free    = pend_free;
    assign sts.pend_valid   = pend_valid_reg;
    assign sts.out_can_load = out_can_load;

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // window never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= FILL_W'(WIN_DEPTH))
        else $error("window fill beyond depth");

    // sticky flags never clear
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((seen_reg & $past(seen_reg)) == $past(seen_reg)))
        else $error("seen flag cleared");

    // record walk stays inside the record
    assert property (@(posedge clk) disable iff (!rst_n) cmd.rec_step |-> pos_reg < rec_len_w)
        else $error("record position past record length");

    // a new result never overwrites a pending one that cannot move on
    assert property (@(posedge clk) disable iff (!rst_n) gen && pend_valid_reg |-> out_can_load)
        else $error("pending result overwritten");

endmodule

FILE: rtl/core/modem_response_field_extractor_top.sv
// top level of the modem response field extractor
//
// channel  direction  signals                              role
// s_*      in         s_tvalid s_tready s_tdata s_tlast     receive bytes, tlast ends buffer
// m_*      out        m_tvalid m_tready m_tdata m_tuser m_tlast  captured bytes and reports
// cfg_*    in         cfg_valid cfg_ready cfg_index cfg_data     quality bound writes
//
// a byte that does not fill the 27 byte window and does not end a buffer is only appended
// any other byte is appended and then starts a scan: unmatched positions shift out, a matched
// keyword starts a record walked through the window shift line, and the finish state closes
// the run; output stalls hold the record walk once the pending and output slots are full
// reset empties the window and sets the bounds to 10 and 40; no clearing pass
module modem_response_field_extractor_top
    import mrfe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // rx_byte
    input  logic                 s_tlast,   // end_of_buffer
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // byte_index, byte_value, signal_quality,
                                            // status_update, imei_seen, iccid_seen, zeros
    output logic [1:0]           m_tuser,   // event_kind
    output logic                 m_tlast,   // last_in_run
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;
    result_t out_item;

    mrfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mrfe_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .rx_byte   (s_tdata),
        .rx_eob    (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_item  (out_item)
    );

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    // result packing
    assign m_tdata = {7'b0, out_item.iccid_seen, out_item.imei_seen, out_item.status,
                      out_item.quality, out_item.byte_value, out_item.byte_index};
    assign m_tuser = out_item.kind;
    assign m_tlast = out_item.last;

endmodule
